/* rtl/sas_pkg.sv */
package sas_pkg;

   // Default configuration
   localparam int HEIGHT_LEVELS_DEF = 256;
   localparam int X_BITS_DEF        = 16;
   localparam int COUNT_BITS_DEF    = 12;

   // Fixed field widths
   localparam int HEIGHT_BITS = 8;
   localparam int AREA_BITS   = 24;

   localparam logic [AREA_BITS-1:0] AREA_MAX = '1;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNMATCHED = 2'd1,
      ST_BACKWARDS = 2'd2,
      ST_SATURATED = 2'd3
   } status_type;

   // Outcome of the count update for the request held in the level store
   typedef struct packed {
      logic unmatched;
      logic saturated;
   } store_flags_type;

endpackage

/* rtl/sas_level_store.sv */
module sas_level_store #(
   parameter int HEIGHT_LEVELS = sas_pkg::HEIGHT_LEVELS_DEF,
   parameter int COUNT_BITS    = sas_pkg::COUNT_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rd_en,
   input  logic [$clog2(HEIGHT_LEVELS)-1:0] rd_addr,
   input  logic                             rd_start,
   input  logic                             commit,
   output logic [HEIGHT_LEVELS-1:0]         occupied,
   output sas_pkg::store_flags_type         flags
);
   import sas_pkg::*;

   localparam int LVL_BITS = $clog2(HEIGHT_LEVELS);

   // Per-level active counts; an entry is meaningful only while its occupied bit is set
   logic [COUNT_BITS-1:0] mem [HEIGHT_LEVELS];

   logic [COUNT_BITS-1:0] rd_data_ff;
   logic [LVL_BITS-1:0]   addr_ff;
   logic                  start_ff;
   logic                  fwd_valid_ff;
   logic [LVL_BITS-1:0]   fwd_addr_ff;
   logic [COUNT_BITS-1:0] fwd_data_ff;
   logic [HEIGHT_LEVELS-1:0] occ_ff;

   logic [COUNT_BITS-1:0] stored;
   logic [COUNT_BITS-1:0] cur;
   logic [COUNT_BITS-1:0] count_in;

   // Current count: forward the last write, mask unoccupied entries to zero
   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == addr_ff)) begin
         stored = fwd_data_ff;
      end else begin
         stored = rd_data_ff;
      end
      cur = occ_ff[addr_ff] ? stored : '0;
   end

   // Count up or down with saturation and unmatched-end detection
   always_comb begin
      flags    = '0;
      count_in = cur;
      if (start_ff) begin
         if (cur == '1) begin
            flags.saturated = 1'b1;
         end else begin
            count_in = cur + COUNT_BITS'(1);
         end
      end else begin
         if (cur == '0) begin
            flags.unmatched = 1'b1;
         end else begin
            count_in = cur - COUNT_BITS'(1);
         end
      end
   end

   // Count memory, read port and held request
   always_ff @(posedge clock) begin
      if (commit) begin
         mem[addr_ff] <= count_in;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         addr_ff    <= rd_addr;
         start_ff   <= rd_start;
      end
      if (commit) begin
         fwd_addr_ff <= addr_ff;
         fwd_data_ff <= count_in;
      end
   end

   // Occupancy bitmap and forward valid
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         fwd_valid_ff <= 1'b0;
      end else if (commit) begin
         occ_ff[addr_ff] <= (count_in != '0);
         fwd_valid_ff    <= 1'b1;
      end
   end

   assign occupied = occ_ff;

endmodule

/* rtl/sas_prio_enc.sv */
module sas_prio_enc #(
   parameter int HEIGHT_LEVELS = sas_pkg::HEIGHT_LEVELS_DEF
) (
   input  logic [HEIGHT_LEVELS-1:0]         occupied,
   output logic [$clog2(HEIGHT_LEVELS)-1:0] level
);
   import sas_pkg::*;

   localparam int LVL_BITS = $clog2(HEIGHT_LEVELS);
   localparam int GW       = 16;
   localparam int NG       = (HEIGHT_LEVELS + GW - 1) / GW;
   localparam int GB       = (NG > 1) ? $clog2(NG) : 1;

   logic [NG*GW-1:0] occ_pad;
   logic [NG-1:0]    group_any;
   logic [GB-1:0]    top_group;
   logic [GW-1:0]    group_bits;
   logic [3:0]       top_bit;

   // Highest occupied group of sixteen levels, then highest level within it
   always_comb begin
      occ_pad   = (NG*GW)'(occupied);
      top_group = '0;
      top_bit   = '0;
      for (int g = 0; g < NG; g++) begin
         group_any[g] = |occ_pad[g*GW +: GW];
      end
      for (int g = 0; g < NG; g++) begin
         if (group_any[g]) begin
            top_group = GB'(g);
         end
      end
      group_bits = occ_pad[top_group*GW +: GW];
      for (int b = 0; b < GW; b++) begin
         if (group_bits[b]) begin
            top_bit = 4'(b);
         end
      end
      level = LVL_BITS'({top_group, top_bit});
   end

endmodule

/* rtl/skyline_area_sweep.sv */
// Skyline area sweep.
// Requests are building edges sorted by x (req_event_x, req_height, req_is_start);
// each one produces exactly one response with the running area under the
// skyline, the highest active level and a status code (ok, unmatched end,
// x went backwards, count saturated).
// Both channels use valid/ready. A request passes through the stage registers
// A, B, C and D in order before its response is presented.
// One request is taken every cycle while responses are taken; the
// per-level count is a read-modify-write on a one-port-write memory with
// a registered read, kept at full rate by forwarding the previous write.
// The four stages each advance when the next one is empty or moving, so a
// stalled receiver fills the pipeline before req_ready drops, and a waiting
// response does not block new requests while a stage is free.
// Reset clears the occupancy bitmap (which marks every count as zero),
// the running maximum, the previous x and the area; no clearing pass runs,
// so requests are accepted right after reset.
module skyline_area_sweep #(
   parameter int HEIGHT_LEVELS = sas_pkg::HEIGHT_LEVELS_DEF,
   parameter int X_BITS        = sas_pkg::X_BITS_DEF,
   parameter int COUNT_BITS    = sas_pkg::COUNT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [X_BITS-1:0]               req_event_x,
   input  logic [sas_pkg::HEIGHT_BITS-1:0] req_height,
   input  logic                            req_is_start,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sas_pkg::AREA_BITS-1:0]   rsp_area_total,
   output logic [sas_pkg::HEIGHT_BITS-1:0] rsp_skyline_height,
   output logic [1:0]                      rsp_status
);
   import sas_pkg::*;

   localparam int LVL_BITS = $clog2(HEIGHT_LEVELS);
   localparam int PW       = LVL_BITS + X_BITS;
   localparam int SW       = ((PW > AREA_BITS) ? PW : AREA_BITS) + 1;

   // Stage valids and flow control
   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff;
   logic en_b, en_c, en_d;
   logic a_move, b_move, c_move;
   logic accept;

   // Payload and state
   logic [X_BITS-1:0]      a_x_ff;
   logic [X_BITS-1:0]      last_x_ff;
   logic [X_BITS-1:0]      b_dx_ff;
   status_type             b_status_ff;
   logic [PW-1:0]          c_prod_ff;
   status_type             c_status_ff;
   logic [LVL_BITS-1:0]    max_ff;
   logic [AREA_BITS-1:0]   area_ff;
   logic [HEIGHT_BITS-1:0] rsp_height_ff;
   status_type             rsp_status_ff;

   logic [LVL_BITS-1:0]      req_level;
   logic [HEIGHT_LEVELS-1:0] occupied;
   logic [LVL_BITS-1:0]      enc_level;
   store_flags_type          flags;
   logic                     backwards;
   logic [X_BITS-1:0]        dx_in;
   status_type               status_in;
   logic [PW-1:0]            prod_in;
   logic [SW-1:0]            sum;
   logic [AREA_BITS-1:0]     area_in;

   // Each stage moves when the one after it is empty or moving
   always_comb begin
      en_d      = !d_valid_ff || rsp_ready;
      en_c      = !c_valid_ff || en_d;
      en_b      = !b_valid_ff || en_c;
      c_move    = c_valid_ff && en_d;
      b_move    = b_valid_ff && en_c;
      a_move    = a_valid_ff && en_b;
      req_ready = !a_valid_ff || en_b;
      accept    = req_valid && req_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (req_ready) a_valid_ff <= req_valid;
         if (en_b) b_valid_ff <= a_valid_ff;
         if (en_c) c_valid_ff <= b_valid_ff;
         if (en_d) d_valid_ff <= c_valid_ff;
      end
   end

   // Heights past the top level fold onto it
   always_comb begin
      if (32'(req_height) >= 32'(HEIGHT_LEVELS)) begin
         req_level = LVL_BITS'(HEIGHT_LEVELS - 1);
      end else begin
         req_level = LVL_BITS'(req_height);
      end
   end

   sas_level_store #(
      .HEIGHT_LEVELS (HEIGHT_LEVELS),
      .COUNT_BITS    (COUNT_BITS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (req_level),
      .rd_start (req_is_start),
      .commit   (a_move),
      .occupied (occupied),
      .flags    (flags)
   );

   sas_prio_enc #(
      .HEIGHT_LEVELS (HEIGHT_LEVELS)
   ) u_enc (
      .occupied (occupied),
      .level    (enc_level)
   );

   // Stage A: x step and status
   always_comb begin
      backwards = (a_x_ff < last_x_ff);
      dx_in     = backwards ? '0 : (a_x_ff - last_x_ff);
      if (backwards) begin
         status_in = ST_BACKWARDS;
      end else if (flags.saturated) begin
         status_in = ST_SATURATED;
      end else if (flags.unmatched) begin
         status_in = ST_UNMATCHED;
      end else begin
         status_in = ST_OK;
      end
   end

   // Stage B: area step uses the height before this request
   assign prod_in = PW'(max_ff) * PW'(b_dx_ff);

   // Stage C: saturating accumulate
   always_comb begin
      sum = SW'(area_ff) + SW'(c_prod_ff);
      if (sum > SW'(AREA_MAX)) begin
         area_in = AREA_MAX;
      end else begin
         area_in = AREA_BITS'(sum);
      end
   end

   // Sweep state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_x_ff <= '0;
         max_ff    <= '0;
         area_ff   <= '0;
      end else begin
         if (a_move && !backwards) last_x_ff <= a_x_ff;
         if (b_move) max_ff <= enc_level;
         if (c_move) area_ff <= area_in;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (accept) begin
         a_x_ff <= req_event_x;
      end
      if (a_move) begin
         b_dx_ff     <= dx_in;
         b_status_ff <= status_in;
      end
      if (b_move) begin
         c_prod_ff   <= prod_in;
         c_status_ff <= b_status_ff;
      end
      if (c_move) begin
         rsp_height_ff <= HEIGHT_BITS'(max_ff);
         rsp_status_ff <= c_status_ff;
      end
   end

   assign rsp_valid          = d_valid_ff;
   assign rsp_area_total     = area_ff;
   assign rsp_skyline_height = rsp_height_ff;
   assign rsp_status         = rsp_status_ff;

endmodule
